@@ src/jsu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the JSON string unescape and UTF-8 validate block.
// No dependencies; imported by every module of the block.
package jsu_pkg;

    // Decoded length counter and length limit width
    localparam int LEN_W = 23;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(64 * 1024);

    // Longest UTF-8 sequence accepted by the checker (lead byte included)
    localparam int MAX_SEQ_BYTES = 6;

    // Result queue depth; three entries must be free to take an input byte
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);
    localparam int MAX_RES  = 3;

    // Scan modes: normal, after backslash, then hex digits left = mode - 1
    localparam logic [2:0] MODE_NORMAL    = 3'd0;
    localparam logic [2:0] MODE_ESC       = 3'd1;
    localparam logic [2:0] MODE_HEX_LAST  = 3'd2;
    localparam logic [2:0] MODE_HEX_FIRST = 3'd5;

    // Done status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_ESC = 3'd1;
    localparam logic [2:0] ST_BAD_HEX = 3'd2;
    localparam logic [2:0] ST_UNTERM  = 3'd3;
    localparam logic [2:0] ST_LONG    = 3'd4;
    localparam logic [2:0] ST_UTF8    = 3'd5;

    // Characters with a special meaning in the string body
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    // UTF-8 encoding constants
    localparam logic [7:0] UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0] UTF8_CONT      = 8'h80;
    localparam logic [7:0] UTF8_CONT_MASK = 8'h3F;
    localparam logic [7:0] ASCII_MASK     = 8'h7F;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       done_res;
        logic [2:0] status;
        logic       last;
    } result_t;

    // Results produced by one accepted input byte
    typedef struct packed {
        logic [1:0]              n;
        result_t [MAX_RES-1:0]   res;
    } push_t;

endpackage

@@ src/jsu_decode.sv @@
`timescale 1ns / 1ps
// String decoder: scan state, escape and \u decoding, length limit, UTF-8 check.
// Depends on jsu_pkg. Produces up to three results per accepted byte.
module jsu_decode (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                text_byte,
    input  logic                      first,
    input  logic                      text_end,
    input  logic [jsu_pkg::LEN_W-1:0] max_length,
    output jsu_pkg::push_t            push
);
    import jsu_pkg::*;

    typedef struct packed {
        logic       ok;
        logic       is_u;
        logic [7:0] ch;
    } esc_t;

    // Simple escape lookup
    function automatic esc_t esc_map(input logic [7:0] c);
        esc_t e;
        e = '{ok: 1'b1, is_u: 1'b0, ch: c};
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: e.ch = c;
            8'h62:   e.ch = 8'h08;
            8'h66:   e.ch = 8'h0C;
            8'h6E:   e.ch = 8'h0A;
            8'h72:   e.ch = 8'h0D;
            8'h74:   e.ch = 8'h09;
            8'h75:   e.is_u = 1'b1;
            default: e.ok = 1'b0;
        endcase
        return e;
    endfunction

    // Hex digit: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = '0;
        if (c inside {[8'h30:8'h39]})
            d = {1'b1, 4'(c - 8'h30)};
        else if (c inside {[8'h41:8'h46]})
            d = {1'b1, 4'(c - 8'h37)};
        else if (c inside {[8'h61:8'h66]})
            d = {1'b1, 4'(c - 8'h57)};
        return d;
    endfunction

    // One UTF-8 checker step: returns {continuation_left, bad}
    function automatic logic [3:0] utf8_step(input logic [2:0] cont, input logic bad,
                                             input logic [7:0] b);
        logic [3:0] ones;
        logic       run;
        logic [2:0] cont_n;
        logic       bad_n;
        ones   = '0;
        run    = 1'b1;
        cont_n = cont;
        bad_n  = bad;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i])
                ones = ones + 4'd1;
            else
                run = 1'b0;
        end
        if (cont != 3'd0) begin
            if ((b & UTF8_LEAD2) == UTF8_CONT)
                cont_n = cont - 3'd1;
            else begin
                bad_n  = 1'b1;
                cont_n = 3'd0;
            end
        end else if (b == 8'h00) begin
            bad_n = 1'b1;
        end else if (b[7]) begin
            if (ones < 4'd2 || ones > 4'(MAX_SEQ_BYTES))
                bad_n = 1'b1;
            else
                cont_n = 3'(ones - 4'd1);
        end
        return {cont_n, bad_n};
    endfunction

    function automatic result_t done_item(input logic [2:0] st);
        return '{out_byte: 8'h00, out_valid: 1'b0, done_res: 1'b1, status: st, last: 1'b0};
    endfunction

    function automatic result_t data_item(input logic [7:0] b);
        return '{out_byte: b, out_valid: 1'b1, done_res: 1'b0, status: ST_OK, last: 1'b0};
    endfunction

    // String state
    logic [2:0]       mode_reg, mode_next;
    logic [15:0]      hex_reg, hex_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       cont_reg, cont_next;
    logic             bad_reg, bad_next;
    logic             fin_reg, fin_next;

    logic [1:0]            n;
    result_t [MAX_RES-1:0] res;

    // Next state and results for the byte on the input ports
    always_comb
    begin
        logic [2:0]       e_mode;
        logic [15:0]      e_hex;
        logic [LEN_W-1:0] e_cnt;
        logic [2:0]       e_cont;
        logic             e_bad;
        logic             e_fin;
        logic [7:0]       b0, b1, b2;
        logic [1:0]       k;
        logic             do_emit;
        logic             short_hex;
        esc_t             esc;
        logic [4:0]       dig;
        logic [15:0]      v;
        logic [3:0]       u1, u2, u3;

        e_mode = first ? MODE_NORMAL : mode_reg;
        e_hex  = first ? 16'h0000 : hex_reg;
        e_cnt  = first ? '0 : cnt_reg;
        e_cont = first ? 3'd0 : cont_reg;
        e_bad  = first ? 1'b0 : bad_reg;
        e_fin  = first ? 1'b0 : fin_reg;

        mode_next = e_mode;
        hex_next  = e_hex;
        cnt_next  = e_cnt;
        cont_next = e_cont;
        bad_next  = e_bad;
        fin_next  = e_fin;

        n         = 2'd0;
        res       = '0;
        b0        = 8'h00;
        b1        = 8'h00;
        b2        = 8'h00;
        k         = 2'd0;
        do_emit   = 1'b0;
        short_hex = 1'b0;
        esc       = esc_map(text_byte);
        dig       = hex_digit(text_byte);
        v         = {e_hex[11:0], dig[3:0]};

        if (!e_fin) begin
            case (e_mode)
                MODE_NORMAL:
                begin
                    if (text_byte == CH_QUOTE) begin
                        fin_next = 1'b1;
                        n        = 2'd1;
                        res[0]   = done_item((e_bad || e_cont != 3'd0) ? ST_UTF8 : ST_OK);
                    end else if (text_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        b0      = text_byte;
                        k       = 2'd1;
                        do_emit = !text_end;
                    end
                end
                MODE_ESC:
                begin
                    if (!esc.ok) begin
                        fin_next = 1'b1;
                        n        = 2'd1;
                        res[0]   = done_item(ST_BAD_ESC);
                    end else if (esc.is_u) begin
                        mode_next = MODE_HEX_FIRST;
                        hex_next  = 16'h0000;
                    end else begin
                        mode_next = MODE_NORMAL;
                        b0        = esc.ch;
                        k         = 2'd1;
                        do_emit   = !text_end;
                    end
                end
                default:
                begin
                    if (!dig[4] || e_mode > MODE_HEX_FIRST) begin
                        fin_next = 1'b1;
                        n        = 2'd1;
                        res[0]   = done_item(ST_BAD_HEX);
                    end else begin
                        hex_next = v;
                        if (e_mode > MODE_HEX_LAST) begin
                            mode_next = e_mode - 3'd1;
                            short_hex = 1'b1;
                        end else begin
                            mode_next = MODE_NORMAL;
                            do_emit   = !text_end;
                            if (v == 16'h0000) begin
                                k = 2'd0;
                            end else if (v < 16'h0080) begin
                                b0 = v[7:0] & ASCII_MASK;
                                k  = 2'd1;
                            end else if (v < 16'h0800) begin
                                b0 = UTF8_LEAD2 | {3'b000, v[10:6]};
                                b1 = UTF8_CONT | ({2'b00, v[5:0]} & UTF8_CONT_MASK);
                                k  = 2'd2;
                            end else begin
                                b0 = 8'hE0 | {4'h0, v[15:12]};
                                b1 = UTF8_CONT | ({2'b00, v[11:6]} & UTF8_CONT_MASK);
                                b2 = UTF8_CONT | ({2'b00, v[5:0]} & UTF8_CONT_MASK);
                                k  = 2'd3;
                            end
                        end
                    end
                end
            endcase

            // Length limit, then emit and run the UTF-8 checker
            u1 = utf8_step(e_cont, e_bad, b0);
            u2 = utf8_step(u1[3:1], u1[0], b1);
            u3 = utf8_step(u2[3:1], u2[0], b2);
            if (do_emit) begin
                if ({1'b0, e_cnt} + {{(LEN_W-1){1'b0}}, k} > {1'b0, max_length}) begin
                    fin_next = 1'b1;
                    n        = 2'd1;
                    res[0]   = done_item(ST_LONG);
                end else begin
                    n        = k;
                    res[0]   = data_item(b0);
                    res[1]   = data_item(b1);
                    res[2]   = data_item(b2);
                    cnt_next = e_cnt + {{(LEN_W-2){1'b0}}, k};
                    case (k)
                        2'd1:    {cont_next, bad_next} = u1;
                        2'd2:    {cont_next, bad_next} = u2;
                        2'd3:    {cont_next, bad_next} = u3;
                        default: {cont_next, bad_next} = {e_cont, e_bad};
                    endcase
                end
            end

            // Text ran out inside the string
            if (text_end && !fin_next) begin
                fin_next = 1'b1;
                n        = 2'd1;
                res[0]   = done_item(short_hex ? ST_BAD_HEX : ST_UNTERM);
            end
        end else begin
            u1 = '0;
            u2 = '0;
            u3 = '0;
        end

        // Mark the final result of this byte
        case (n)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            2'd3:    res[2].last = 1'b1;
            default: ;
        endcase
    end

    assign push.n   = accept ? n : 2'd0;
    assign push.res = res;

    // State registers, updated on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_NORMAL;
            hex_reg  <= '0;
            cnt_reg  <= '0;
            cont_reg <= '0;
            bad_reg  <= 1'b0;
            fin_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            cnt_reg  <= cnt_next;
            cont_reg <= cont_next;
            bad_reg  <= bad_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

@@ src/jsu_resq.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to three results per cycle, hands out one per cycle
// while pop is high. Depends on jsu_pkg.
module jsu_resq (
    input  logic             clk,
    input  logic             rst_n,
    input  jsu_pkg::push_t   push,
    input  logic             pop,
    output jsu_pkg::result_t head,
    output logic             head_valid,
    output logic             full
);
    import jsu_pkg::*;

    result_t          entries_reg [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_reg, rd_reg;
    logic [RQ_CW-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    assign do_pop     = pop && (cnt_reg != '0);
    assign head       = entries_reg[rd_reg];
    assign head_valid = (cnt_reg != '0);
    // Not enough room for the worst case of one input byte
    assign full       = (cnt_reg > RQ_CW'(RQ_DEPTH - MAX_RES));

    assign cnt_next = cnt_reg + RQ_CW'(push.n) - RQ_CW'(do_pop);

    // Entry writes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < push.n)
                entries_reg[wr_reg + RQ_AW'(i)] <= push.res[i];
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + RQ_AW'(push.n);
            rd_reg  <= rd_reg + RQ_AW'(do_pop);
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/json_string_unescape_validate_top.sv @@
`timescale 1ns / 1ps
// Top level of the JSON string unescape and UTF-8 validate block.
// Depends on jsu_pkg, jsu_decode and jsu_resq.
//
// Usage:
//   Input channel (in_valid/in_stall): one raw string-body byte per transfer,
//   with first marking the byte after an opening quote and text_end the last
//   byte of the text. Output channel (res_valid/res_stall): one result per
//   transfer, either a decoded byte (out_valid) or the end of the string
//   (done_res with status). last flags the final result of an input byte.
//   An input byte is decoded in the cycle it is taken; its results are
//   registered in the result queue and offered on the output from there.
//   One input byte is taken per cycle as long as the downstream keeps up; a \u
//   escape that expands to two or three UTF-8 bytes needs that many output
//   transfers; the four-entry result queue sets how far the input runs ahead.
//   in_stall rises when fewer than three queue entries are free. When the
//   receiver stalls, the head result holds and the queue fills, then the input
//   stalls. Reset clears the string state and the queue and loads max_length
//   with 65536. cfg_ready is always high; write max_length only while idle.
module json_string_unescape_validate_top (
    input  logic                      clk,
    input  logic                      rst_n,
    // Input byte channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                text_byte,
    input  logic                      first,
    input  logic                      text_end,
    // Result channel
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic [7:0]                out_byte,
    output logic                      out_valid,
    output logic                      done_res,
    output logic [2:0]                status,
    output logic                      last,
    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [jsu_pkg::LEN_W-1:0] cfg_data
);
    import jsu_pkg::*;

    logic [LEN_W-1:0] max_length_reg;
    logic             accept;
    push_t            push;
    result_t          head;
    logic             full;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !full;

    // Length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LEN_RESET;
        else if (cfg_valid && cfg_ready)
            max_length_reg <= cfg_data;
    end

    jsu_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_byte  (text_byte),
        .first      (first),
        .text_end   (text_end),
        .max_length (max_length_reg),
        .push       (push)
    );

    jsu_resq u_resq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (!res_stall),
        .head       (head),
        .head_valid (res_valid),
        .full       (full)
    );

    assign out_byte  = head.out_byte;
    assign out_valid = head.out_valid;
    assign done_res  = head.done_res;
    assign status    = head.status;
    assign last      = head.last;

endmodule

@@ src/jsu_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the JSON string decoder, bound to the top level.
// Depends on jsu_pkg.
module jsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       res_valid,
    input logic       res_stall,
    input logic       out_valid,
    input logic       done_res,
    input logic [2:0] status,
    input logic       last
);
    import jsu_pkg::*;

    // A stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // Every result is either a data byte or the end of the string
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (out_valid != done_res))
        else $error("result is neither data nor done, or both");

    // The end of a string is always the final result of its byte
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> last)
        else $error("done result not marked last");

    // Data results carry no error status
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> (status == ST_OK))
        else $error("data result with error status");

    // With nothing queued the input is never stalled
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !in_stall)
        else $error("input stalled with empty result queue");

endmodule

bind json_string_unescape_validate_top jsu_checker u_jsu_checker (.*);
